// ===== hdl/es2utc_pkg.sv =====
// ----------------------------------------------------------------------------
// es2utc_pkg
// Shared types, constants and calendar functions for the epoch-seconds to
// UTC calendar converter.
// ----------------------------------------------------------------------------
package es2utc_pkg;

	localparam int unsigned EpochW   = 32;
	localparam int unsigned DaysW    = 16;
	localparam int unsigned RemW     = 17;
	localparam int unsigned YearW    = 8;
	localparam int unsigned YdayW    = 9;
	localparam int unsigned OutDataW = 48;
	localparam int unsigned MulAW    = 25;
	localparam int unsigned MulBW    = 26;
	localparam int unsigned ProdW    = 51;

	// Each divisor is split into a power of two and an odd factor. The odd factor
	// is divided by multiplying with the rounded-up reciprocal, which is exact
	// over the whole operand range: 2^35 / 675, 2^19 / 7, 2^21 / 225, 2^14 / 15.
	localparam logic [MulBW-1:0] RecipDay  = 26'd50903317;
	localparam logic [MulBW-1:0] RecipWeek = 26'd74899;
	localparam logic [MulBW-1:0] RecipHour = 26'd9321;
	localparam logic [MulBW-1:0] RecipMin  = 26'd1093;

	localparam logic [9:0] DayDivisor  = 10'd675;
	localparam logic [2:0] WeekDivisor = 3'd7;
	localparam logic [7:0] HourDivisor = 8'd225;
	localparam logic [3:0] MinDivisor  = 4'd15;

	// Weekday of 1970-01-01 (Thursday) and the first year relative to 1900.
	localparam logic [DaysW-1:0] EpochWeekday = 16'd4;
	localparam logic [YearW-1:0] FirstYear    = 8'd70;
	localparam logic [3:0]       LastMonth    = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_DAY,
		ST_DIV_WEEK,
		ST_DIV_HOUR,
		ST_DIV_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_WEEK,
		DIV_HOUR,
		DIV_MIN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		div_sel_t div_sel;
		logic     year_step;
		logic     month_step;
		logic     publish;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic year_done;
		logic month_done;
	} sts_t;

	// Leap rule over 1900 + y for any 8-bit y: 1900 and 2100 are the only
	// century years in range that are not leap years.
	function automatic logic is_leap(input logic [YearW-1:0] y);
		return (y[1:0] == 2'd0) && (y != 8'd0) && (y != 8'd200);
	endfunction

	function automatic logic [YdayW-1:0] year_len(input logic [YearW-1:0] y);
		return is_leap(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd1:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd30;
		endcase
		return len;
	endfunction

endpackage

// ===== hdl/epoch_seconds_to_utc_calendar_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_core
// Converts unsigned seconds since 1970-01-01 00:00:00 UTC to broken-down
// Gregorian UTC calendar time.
// ----------------------------------------------------------------------------
// Each input word is taken when the core is idle and converted step by step:
// four divisions by constants (86400, 7, 3600 and 60), each a reciprocal
// multiply followed by a remainder step, then a walk over the whole years
// since 1970 and a walk over the whole months into the year, and last the
// load of the result word into the output register. The core goes back to
// idle after that load and can then take the next input word, so it does not
// take a new word before it is through with the last one. A finished word
// sits in its own output register, so the next input word is accepted while
// the previous result still waits for the sink; a new result only waits if
// the previous one has not yet gone.
module epoch_seconds_to_utc_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
	// [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
	// [45:41] day_of_month, [47:46] zero
	output logic [47:0] m_tdata
);

	es2utc_pkg::cmd_t cmd;
	es2utc_pkg::sts_t sts;

	es2utc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	es2utc_dp u_dp (
		.clk           (clk),
		.epoch_seconds (s_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.result        (m_tdata)
	);

endmodule

// ===== hdl/es2utc_ctrl.sv =====
// ----------------------------------------------------------------------------
// es2utc_ctrl
// Sequencer for the converter: steps the datapath through the four
// divisions, the year walk and the month walk, and owns the output valid.
// ----------------------------------------------------------------------------
module es2utc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  es2utc_pkg::sts_t   sts,
	output es2utc_pkg::cmd_t   cmd
);

	es2utc_pkg::state_t state_q, state_d;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= es2utc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = es2utc_pkg::DIV_DAY;
		s_tready    = 1'b0;
		case (state_q)
			es2utc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = es2utc_pkg::ST_DIV_DAY;
				end
			end
			es2utc_pkg::ST_DIV_DAY: begin
				cmd.div_step = 1'b1;
				cmd.div_sel  = es2utc_pkg::DIV_DAY;
				if (sts.div_last) begin
					state_d = es2utc_pkg::ST_DIV_WEEK;
				end
			end
			es2utc_pkg::ST_DIV_WEEK: begin
				cmd.div_step = 1'b1;
				cmd.div_sel  = es2utc_pkg::DIV_WEEK;
				if (sts.div_last) begin
					state_d = es2utc_pkg::ST_DIV_HOUR;
				end
			end
			es2utc_pkg::ST_DIV_HOUR: begin
				cmd.div_step = 1'b1;
				cmd.div_sel  = es2utc_pkg::DIV_HOUR;
				if (sts.div_last) begin
					state_d = es2utc_pkg::ST_DIV_MIN;
				end
			end
			es2utc_pkg::ST_DIV_MIN: begin
				cmd.div_step = 1'b1;
				cmd.div_sel  = es2utc_pkg::DIV_MIN;
				if (sts.div_last) begin
					state_d = es2utc_pkg::ST_YEAR;
				end
			end
			es2utc_pkg::ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (sts.year_done) begin
					state_d = es2utc_pkg::ST_MONTH;
				end
			end
			es2utc_pkg::ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_done) begin
					state_d = es2utc_pkg::ST_DONE;
				end
			end
			es2utc_pkg::ST_DONE: begin
				// The result register is free once its previous word has gone.
				if (!out_valid_q || m_tready) begin
					cmd.publish = 1'b1;
					state_d     = es2utc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = es2utc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== hdl/es2utc_dp.sv =====
// ----------------------------------------------------------------------------
// es2utc_dp
// Datapath: a shared reciprocal multiplier for the divisions by constants,
// the year and month subtractors, and the result register.
// ----------------------------------------------------------------------------
module es2utc_dp (
	input  logic                                  clk,
	input  logic [es2utc_pkg::EpochW-1:0]         epoch_seconds,
	input  es2utc_pkg::cmd_t                      cmd,
	output es2utc_pkg::sts_t                      sts,
	output logic [es2utc_pkg::OutDataW-1:0]       result
);

	logic [es2utc_pkg::EpochW-1:0]  epoch_q;
	logic                           phase_q;
	logic [es2utc_pkg::MulAW-1:0]   mul_a;
	logic [es2utc_pkg::MulBW-1:0]   mul_b;
	logic [es2utc_pkg::ProdW-1:0]   mul_p;
	logic [es2utc_pkg::ProdW-1:0]   prod_q;

	logic [es2utc_pkg::DaysW-1:0]   day_quo;
	logic [es2utc_pkg::MulAW-1:0]   day_back;
	logic [9:0]                     day_rem;
	logic [es2utc_pkg::DaysW-1:0]   week_num;
	logic [12:0]                    week_quo;
	logic [es2utc_pkg::DaysW-1:0]   week_back;
	logic [2:0]                     wday_nxt;
	logic [4:0]                     hour_quo;
	logic [12:0]                    hour_back;
	logic [7:0]                     hour_rem;
	logic [5:0]                     min_quo;
	logic [9:0]                     min_back;
	logic [3:0]                     min_rem;

	logic [es2utc_pkg::DaysW-1:0]   days_q;
	logic [es2utc_pkg::RemW-1:0]    sod_q;
	logic [11:0]                    rem_q;
	logic [es2utc_pkg::YearW-1:0]   year_q;
	logic [3:0]                     mon_q;
	logic [es2utc_pkg::YdayW-1:0]   yday_q;
	logic [5:0]                     sec_q;
	logic [5:0]                     min_q;
	logic [4:0]                     hour_q;
	logic [2:0]                     wday_q;
	logic [es2utc_pkg::YdayW-1:0]   ylen;
	logic [4:0]                     mlen;

	logic [es2utc_pkg::OutDataW-1:0] out_q;

	assign week_num = days_q + es2utc_pkg::EpochWeekday;

	// The power-of-two part of each divisor is shifted off before the multiply
	// and joined back onto the remainder afterwards.
	always_comb begin
		case (cmd.div_sel)
			es2utc_pkg::DIV_DAY: begin
				mul_a = epoch_q[31:7];
				mul_b = es2utc_pkg::RecipDay;
			end
			es2utc_pkg::DIV_WEEK: begin
				mul_a = {9'd0, week_num};
				mul_b = es2utc_pkg::RecipWeek;
			end
			es2utc_pkg::DIV_HOUR: begin
				mul_a = {12'd0, sod_q[16:4]};
				mul_b = es2utc_pkg::RecipHour;
			end
			es2utc_pkg::DIV_MIN: begin
				mul_a = {15'd0, rem_q[11:2]};
				mul_b = es2utc_pkg::RecipMin;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

	assign day_quo   = prod_q[50:35];
	assign day_back  = {9'd0, day_quo} * {15'd0, es2utc_pkg::DayDivisor};
	assign day_rem   = 10'(epoch_q[31:7] - day_back);
	assign week_quo  = prod_q[31:19];
	assign week_back = {3'd0, week_quo} * {13'd0, es2utc_pkg::WeekDivisor};
	assign wday_nxt  = 3'(week_num - week_back);
	assign hour_quo  = prod_q[25:21];
	assign hour_back = {8'd0, hour_quo} * {5'd0, es2utc_pkg::HourDivisor};
	assign hour_rem  = 8'(sod_q[16:4] - hour_back);
	assign min_quo   = prod_q[19:14];
	assign min_back  = {4'd0, min_quo} * {6'd0, es2utc_pkg::MinDivisor};
	assign min_rem   = 4'(rem_q[11:2] - min_back);

	assign ylen = es2utc_pkg::year_len(year_q);
	assign mlen = es2utc_pkg::month_len(es2utc_pkg::is_leap(year_q), mon_q);

	assign sts.div_last   = phase_q;
	assign sts.year_done  = days_q < {7'd0, ylen};
	assign sts.month_done = (mon_q == es2utc_pkg::LastMonth) || (days_q < {11'd0, mlen});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			epoch_q <= epoch_seconds;
			phase_q <= 1'b0;
		end else if (cmd.div_step) begin
			phase_q <= ~phase_q;
			if (!phase_q) begin
				prod_q <= mul_p;
			end else begin
				// Second phase of one division: keep the quotient and remainder.
				case (cmd.div_sel)
					es2utc_pkg::DIV_DAY: begin
						days_q <= day_quo;
						sod_q  <= {day_rem, epoch_q[6:0]};
					end
					es2utc_pkg::DIV_WEEK: begin
						wday_q <= wday_nxt;
					end
					es2utc_pkg::DIV_HOUR: begin
						hour_q <= hour_quo;
						rem_q  <= {hour_rem, sod_q[3:0]};
					end
					es2utc_pkg::DIV_MIN: begin
						min_q  <= min_quo;
						sec_q  <= {min_rem, rem_q[1:0]};
						year_q <= es2utc_pkg::FirstYear;
						mon_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end else if (cmd.year_step) begin
			if (!sts.year_done) begin
				days_q <= days_q - {7'd0, ylen};
				year_q <= year_q + 8'd1;
			end else begin
				yday_q <= days_q[es2utc_pkg::YdayW-1:0];
			end
		end else if (cmd.month_step) begin
			if (!sts.month_done) begin
				days_q <= days_q - {11'd0, mlen};
				mon_q  <= mon_q + 4'd1;
			end
		end else if (cmd.publish) begin
			out_q <= {2'd0, 5'(days_q[4:0] + 5'd1), mon_q, yday_q, year_q,
			          wday_q, hour_q, min_q, sec_q};
		end
	end

	assign result = out_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the epoch-seconds to UTC calendar core. A short
// table of hand-picked timestamps (epoch start, day, month, leap and century
// edges, the top of the 32-bit range) is followed by random timestamps aimed
// mostly at day, month and year boundaries. Each word's expected date is
// hand-written or comes from a behavioural calendar model, and each result
// word is checked field by field against the oldest pending date.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned DaySeconds  = 86400;
	localparam int unsigned HourSeconds = 3600;
	localparam int unsigned MinSeconds  = 60;
	localparam int unsigned EpochYear   = 1970;
	localparam int unsigned CenturyBase = 1900;
	localparam int unsigned LastDay     = 49710;  // day number of 2106-02-07
	localparam int unsigned RandomWords = 1425;
	localparam int unsigned DrainCycles = 300;

	// Result word layout, most significant field first.
	typedef struct packed {
		logic [1:0] padding;
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [8:0] day_of_year;
		logic [7:0] years_since_1900;
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} calendar_t;

	typedef struct {
		logic [31:0] secs;
		bit          known;
		calendar_t   date;
	} vector_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	calendar_t pending_dates[$];
	vector_t   vectors[$];
	int        mismatches    = 0;
	int        src_idle_pct  = 0;
	int        sink_idle_pct = 0;

	epoch_seconds_to_utc_calendar_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic bit gregorian_leap(input int unsigned year);
		return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned year,
			input int unsigned mon);
		int unsigned len;
		case (mon)
			1:             len = gregorian_leap(year) ? 29 : 28;
			3, 5, 8, 10:   len = 30;
			default:       len = 31;
		endcase
		return len;
	endfunction

	function automatic calendar_t utc_from_epoch(input logic [31:0] secs);
		int unsigned tod, days, year, ylen, mon;
		calendar_t   date;
		tod  = secs % DaySeconds;
		days = secs / DaySeconds;
		date = '0;
		date.second  = 6'(tod % MinSeconds);
		date.minute  = 6'((tod % HourSeconds) / MinSeconds);
		date.hour    = 5'(tod / HourSeconds);
		date.weekday = 3'((days + 4) % 7);
		year = EpochYear;
		ylen = gregorian_leap(year) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			year++;
			ylen = gregorian_leap(year) ? 366 : 365;
		end
		date.years_since_1900 = 8'(year - CenturyBase);
		date.day_of_year      = 9'(days);
		mon = 0;
		while (mon < 11 && days >= days_in_month(year, mon)) begin
			days -= days_in_month(year, mon);
			mon++;
		end
		date.month        = 4'(mon);
		date.day_of_month = 5'(days + 1);
		return date;
	endfunction

	// Seconds at midnight on the first day of the given month.
	function automatic longint month_start_secs(input int unsigned year,
			input int unsigned mon);
		longint days;
		days = 0;
		for (int unsigned y = EpochYear; y < year; y++)
			days += gregorian_leap(y) ? 366 : 365;
		for (int unsigned m = 0; m < mon; m++)
			days += days_in_month(year, m);
		return days * DaySeconds;
	endfunction

	function automatic calendar_t make_date(input int sec, input int min, input int hr,
			input int wday, input int yr, input int yday, input int mon, input int mday);
		calendar_t date;
		date = '0;
		date.second           = 6'(sec);
		date.minute           = 6'(min);
		date.hour             = 5'(hr);
		date.weekday          = 3'(wday);
		date.years_since_1900 = 8'(yr);
		date.day_of_year      = 9'(yday);
		date.month            = 4'(mon);
		date.day_of_month     = 5'(mday);
		return date;
	endfunction

	task automatic add_vector(input logic [31:0] secs, input bit known, input calendar_t date);
		vector_t v;
		v.secs  = secs;
		v.known = known;
		v.date  = date;
		vectors.push_back(v);
	endtask

	task automatic add_predicted(input logic [31:0] secs);
		add_vector(secs, 1'b0, '0);
	endtask

	// Presents one word from a falling edge and returns on the falling edge
	// after it has been taken, with its date queued for checking.
	task automatic offer_epoch(input logic [31:0] secs, input calendar_t date);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= secs;
		do @(posedge clk); while (!s_tready);
		pending_dates.push_back(date);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_epoch();
		longint      secs;
		int unsigned sel, year, mon;
		sel = $urandom_range(99);
		if (sel < 35) begin
			secs = longint'($urandom);
		end else if (sel < 70) begin
			year = $urandom_range(2106, EpochYear);
			mon  = (year == 2106) ? $urandom_range(1, 0) : $urandom_range(11, 0);
			secs = month_start_secs(year, mon);
			case ($urandom_range(3))
				0:       secs = secs - 1;
				1:       secs = secs;
				2:       secs = secs + $urandom_range(DaySeconds - 1);
				default: secs = secs - 1 - $urandom_range(DaySeconds - 1);
			endcase
		end else if (sel < 90) begin
			secs = longint'($urandom_range(LastDay)) * DaySeconds;
			if ($urandom_range(1))
				secs = secs + $urandom_range(HourSeconds + 1);
			else
				secs = secs + DaySeconds - 1 - $urandom_range(HourSeconds + 1);
		end else if (sel < 95) begin
			secs = longint'($urandom_range(500));
		end else begin
			secs = 64'hFFFF_FFFF - $urandom_range(500);
		end
		if (secs < 0 || secs > 64'hFFFF_FFFF)
			secs = longint'($urandom);
		return secs[31:0];
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : result_check
		calendar_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_dates.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_dates.pop_front();
				check_field("second", 32'(want.second), 32'(got.second));
				check_field("minute", 32'(want.minute), 32'(got.minute));
				check_field("hour", 32'(want.hour), 32'(got.hour));
				check_field("weekday", 32'(want.weekday), 32'(got.weekday));
				check_field("years_since_1900", 32'(want.years_since_1900),
					32'(got.years_since_1900));
				check_field("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
				check_field("month", 32'(want.month), 32'(got.month));
				check_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
				check_field("padding", 32'(want.padding), 32'(got.padding));
			end
		end
	end

	initial begin
		#20000000;
		$display("[epoch_seconds_to_utc_calendar_core] ERROR");
		$finish;
	end

	initial begin
		// Dates that can be read straight off the calendar.
		add_vector(32'd0, 1'b1, make_date(0, 0, 0, 4, 70, 0, 0, 1));
		add_vector(32'd86399, 1'b1, make_date(59, 59, 23, 4, 70, 0, 0, 1));
		add_vector(32'd86400, 1'b1, make_date(0, 0, 0, 5, 70, 1, 0, 2));
		add_vector(32'd31536000, 1'b1, make_date(0, 0, 0, 5, 71, 0, 0, 1));
		add_vector(32'hFFFF_FFFF, 1'b1, make_date(15, 28, 6, 0, 206, 37, 1, 7));
		// Minute and hour carries.
		add_predicted(32'd59);
		add_predicted(32'd60);
		add_predicted(32'd3599);
		add_predicted(32'd3600);
		// First leap day and last day of a leap year.
		add_predicted(32'd68169600);
		add_predicted(32'd94694399);
		add_predicted(32'd94694400);
		// Turn of the millennium; 2000 is a leap year despite being a century.
		add_predicted(32'd946684799);
		add_predicted(32'd946684800);
		add_predicted(32'd951782400);
		add_predicted(32'd978307199);
		// The signed 32-bit rollover.
		add_predicted(32'd2147483647);
		add_predicted(32'd2147483648);
		// 2100 is not a leap year, so 28 February runs straight into March.
		add_predicted(32'd4107542399);
		add_predicted(32'd4107542400);
		// Entry into the last year in range, and alternating bit patterns.
		add_predicted(32'd4291747199);
		add_predicted(32'd4291747200);
		add_predicted(32'hAAAA_AAAA);
		add_predicted(32'h5555_5555);
		add_predicted(32'hFFFF_FFFE);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct  = 23;
		sink_idle_pct = 45;
		foreach (vectors[i])
			offer_epoch(vectors[i].secs,
				vectors[i].known ? vectors[i].date : utc_from_epoch(vectors[i].secs));

		for (int n = 0; n < RandomWords; n++) begin
			if (n == RandomWords / 3) begin
				src_idle_pct  = 45;
				sink_idle_pct = 23;
			end else if (n == 2 * RandomWords / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			begin : one_word
				logic [31:0] secs;
				secs = random_epoch();
				offer_epoch(secs, utc_from_epoch(secs));
			end
		end
		s_tvalid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("[epoch_seconds_to_utc_calendar_core] OK");
		else
			$display("[epoch_seconds_to_utc_calendar_core] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/es2utc_pkg.sv
hdl/es2utc_ctrl.sv
hdl/es2utc_dp.sv
hdl/epoch_seconds_to_utc_calendar_core.sv
bench/testbench.sv
